>>> hw/rtl/swzd_pkg.sv
package swzd_pkg;

	localparam int SAMPLE_W = 32;
	localparam int TAG_W    = 32;
	localparam int TIME_W   = 64;
	localparam int SUM_W    = 40;
	localparam int SSQ_W    = 56;
	localparam int LEN_W    = 9;
	localparam int THR_W    = 30;
	localparam int DEV_W    = 31;

	localparam logic CFG_WINDOW_LENGTH   = 1'b0;
	localparam logic CFG_ALERT_THRESHOLD = 1'b1;

	localparam logic [LEN_W-1:0] LEN_RESET = 9'd32;
	localparam logic [THR_W-1:0] THR_RESET = 30'd196608;

	// divider operation codes
	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_SSQ,
		DIV_ROOT,
		DIV_Z
	} div_op_t;

endpackage

>>> hw/rtl/sliding_window_zscore_detector_unit.sv
// from the accepted beat to the result beat, the work goes through one shared 64-bit restoring
// divider (one quotient bit a cycle) that serves the mean, the variance, the root and the
// z-score; the root runs at most 24 Newton steps, fewer when it settles early.
// throughput: one item at a time; s_axis_tready is low while an item is at work.
// reset: arst_n asynchronously clears the slot table, the output valid and control; window
// memory and data registers are not cleared; configuration returns to 32 and 196608.
module sliding_window_zscore_detector_unit #(
	parameter int SENSOR_SLOTS = 8,
	parameter int WINDOW_MAX   = 256,
	parameter int FRAC_BITS    = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // sensor_tag, sample_value, sample_time
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [223:0] m_axis_tdata,   // alert_time, alert_sensor, alert_value, window_mean,
	                                     // window_deviation, z_score, zero fill
	output logic         m_axis_tuser,   // severity
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import swzd_pkg::*;

	localparam int SLOT_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
	localparam int POS_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int MEM_D  = SENSOR_SLOTS * WINDOW_MAX;
	localparam int ADDR_W = $clog2(MEM_D);
	localparam logic [63:0] VAR_CAP = (64'd1 << (63 - FRAC_BITS)) - 64'd1;
	localparam logic [63:0] ONE_FP  = 64'd1 << FRAC_BITS;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOOK   = 4'd1;
	localparam logic [3:0] ST_RDOLD  = 4'd2;
	localparam logic [3:0] ST_UPD    = 4'd3;
	localparam logic [3:0] ST_DIV    = 4'd4;
	localparam logic [3:0] ST_MEANS  = 4'd5;
	localparam logic [3:0] ST_VAR    = 4'd6;
	localparam logic [3:0] ST_ROOTS  = 4'd7;
	localparam logic [3:0] ST_ROOTN  = 4'd8;
	localparam logic [3:0] ST_ZS     = 4'd9;
	localparam logic [3:0] ST_ZDONE  = 4'd10;
	localparam logic [3:0] ST_OUT    = 4'd11;
	localparam logic [3:0] ST_SQOLD  = 4'd12;
	localparam logic [3:0] ST_MSQ    = 4'd13;

	logic [3:0] state_q;

	logic [LEN_W-1:0] len_cfg_q;
	logic [THR_W-1:0] thr_q;

	logic [SENSOR_SLOTS-1:0] used_q;
	logic [TAG_W-1:0] id_q  [SENSOR_SLOTS];
	logic [POS_W-1:0] pos_q [SENSOR_SLOTS];
	logic [CNT_W-1:0] fill_q[SENSOR_SLOTS];
	logic [SUM_W-1:0] sum_q [SENSOR_SLOTS];
	logic [SSQ_W-1:0] ssq_q [SENSOR_SLOTS];

	logic [SAMPLE_W-1:0] mem_q [MEM_D];
	logic [SAMPLE_W-1:0] rd_q;

	logic [TAG_W-1:0]    tag_q;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic [TIME_W-1:0]   ts_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    len_q;
	logic [POS_W-1:0]    cpos_q;
	logic [CNT_W-1:0]    fill_new_q;
	logic                evict_q;
	logic [SUM_W-1:0]    sum_new_q;
	logic [SSQ_W-1:0]    ssq_new_q;
	logic [63:0]         sqold_q;

	logic signed [63:0]  mean_q;
	logic [63:0]         var_q;
	logic [63:0]         x_q;
	logic [4:0]          step_q;
	logic [63:0]         dev_q;
	logic signed [63:0]  z_q;
	logic                sev_q;
	logic [223:0]        out_q;
	logic                sev_out_q;
	logic                out_v_q;

	// shared divider
	logic [63:0] dn_q, dd_q, dq_q, dr_q;
	logic [6:0]  dcnt_q;
	logic        dneg_q;
	div_op_t     dop_q;
	logic [64:0] dtrial;
	assign dtrial = {dr_q, dn_q[63]} - {1'b0, dd_q};

	// shared multiplier, 32x32, combinational
	logic [31:0] mul_a_q;
	logic [63:0] mul_p;
	assign mul_p = {32'd0, mul_a_q} * {32'd0, mul_a_q};

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	// lookup
	logic               hit, freeslot;
	logic [SLOT_W-1:0]  hit_idx, free_idx;
	always_comb begin
		hit = 1'b0; freeslot = 1'b0; hit_idx = '0; free_idx = '0;
		for (int i = SENSOR_SLOTS - 1; i >= 0; i--) begin
			if (used_q[i] && id_q[i] == tag_q) begin
				hit = 1'b1; hit_idx = SLOT_W'(i);
			end
			if (!used_q[i]) begin
				freeslot = 1'b1; free_idx = SLOT_W'(i);
			end
		end
	end

	logic [CNT_W-1:0] len_eff;
	always_comb begin
		if (len_cfg_q == '0) len_eff = CNT_W'(1);
		else if ({23'd0, len_cfg_q} > WINDOW_MAX) len_eff = CNT_W'(WINDOW_MAX);
		else len_eff = CNT_W'(len_cfg_q);
	end

	logic [ADDR_W-1:0] addr;
	assign addr = ADDR_W'(slot_q) * ADDR_W'(WINDOW_MAX) + ADDR_W'(cpos_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tuser  = sev_out_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_RDOLD) rd_q <= mem_q[addr];
		if (state_q == ST_UPD)   mem_q[addr] <= smp_q;
	end

	logic signed [63:0] newton_next, newton_diff;
	always_comb begin
		newton_next = 64'((x_q + dq_q) >> 1);
		newton_diff = (newton_next > $signed(x_q)) ? newton_next - $signed(x_q)
		                                           : $signed(x_q) - newton_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_cfg_q <= LEN_RESET;
			thr_q     <= THR_RESET;
			used_q    <= '0;
			out_v_q   <= 1'b0;
			dcnt_q    <= '0;
			for (int i = 0; i < SENSOR_SLOTS; i++) begin
				id_q[i] <= '0; pos_q[i] <= '0; fill_q[i] <= '0;
				sum_q[i] <= '0; ssq_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_WINDOW_LENGTH) len_cfg_q <= cfg_data[LEN_W-1:0];
				else thr_q <= cfg_data[THR_W-1:0];
			end
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					tag_q   <= s_axis_tdata[31:0];
					smp_q   <= s_axis_tdata[63:32];
					ts_q    <= s_axis_tdata[127:64];
					len_q   <= len_eff;
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (!hit && !freeslot) state_q <= ST_IDLE;
					else begin
						logic [SLOT_W-1:0] s;
						logic [POS_W-1:0] p;
						logic [CNT_W-1:0] f;
						s = hit ? hit_idx : free_idx;
						slot_q <= s;
						p = hit ? pos_q[s] : '0;
						f = hit ? fill_q[s] : '0;
						if (!hit) begin
							used_q[s] <= 1'b1; id_q[s] <= tag_q; pos_q[s] <= '0;
							fill_q[s] <= '0; sum_q[s] <= '0; ssq_q[s] <= '0;
							sum_new_q <= '0; ssq_new_q <= '0;
						end else begin
							sum_new_q <= sum_q[s]; ssq_new_q <= ssq_q[s];
						end
						if (CNT_W'(p) >= len_q) p = '0;
						cpos_q <= p;
						evict_q <= (f >= len_q);
						fill_new_q <= (f >= len_q) ? f : f + CNT_W'(1);
						state_q <= ST_RDOLD;
					end
				end
				ST_RDOLD: state_q <= ST_SQOLD;
				ST_SQOLD: begin
					mul_a_q <= evict_q ? 32'(mag({{32{rd_q[31]}}, rd_q})) : 32'd0;
					state_q <= ST_MSQ;
				end
				ST_MSQ: begin
					sqold_q <= evict_q ? (mul_p >> FRAC_BITS) : 64'd0;
					if (evict_q) sum_new_q <= sum_new_q - SUM_W'($signed(rd_q));
					mul_a_q <= 32'(mag(64'(smp_q)));
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					logic [SUM_W-1:0] sn;
					logic [SSQ_W-1:0] qn;
					logic [POS_W:0] np;
					sn = sum_new_q + SUM_W'(smp_q);
					qn = ssq_new_q - SSQ_W'(sqold_q) + SSQ_W'(mul_p >> FRAC_BITS);
					np = {1'b0, cpos_q} + 1'b1;
					sum_q[slot_q]  <= sn; ssq_q[slot_q] <= qn;
					sum_new_q      <= sn; ssq_new_q     <= qn;
					fill_q[slot_q] <= fill_new_q;
					pos_q[slot_q]  <= (CNT_W'(np) >= len_q) ? '0 : POS_W'(np);
					if (fill_new_q < CNT_W'(2)) state_q <= ST_IDLE;
					else begin
						logic signed [63:0] sv;
						sv = 64'($signed(sn));
						dn_q <= mag(sv); dd_q <= 64'(fill_new_q); dneg_q <= sv[63];
						dr_q <= '0; dq_q <= '0; dcnt_q <= 7'd64; dop_q <= DIV_MEAN;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dcnt_q != 0) begin
						if (!dtrial[64]) begin
							dr_q <= dtrial[63:0]; dq_q <= {dq_q[62:0], 1'b1};
						end else begin
							dr_q <= {dr_q[62:0], dn_q[63]}; dq_q <= {dq_q[62:0], 1'b0};
						end
						dn_q <= {dn_q[62:0], 1'b0};
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						case (dop_q)
							DIV_MEAN: state_q <= ST_MEANS;
							DIV_SSQ:  state_q <= ST_VAR;
							DIV_ROOT: state_q <= ST_ROOTN;
							default:  state_q <= ST_ZDONE;
						endcase
					end
				end
				ST_MEANS: begin
					logic signed [63:0] m;
					m = dneg_q ? -$signed(dq_q) : $signed(dq_q);
					if (m > 64'sd2147483647) m = 64'sd2147483647;
					if (m < -64'sd2147483648) m = -64'sd2147483648;
					mean_q  <= m;
					mul_a_q <= 32'(mag(m));
					begin
						logic signed [63:0] qv;
						qv = 64'($signed(ssq_new_q));
						dn_q <= mag(qv); dneg_q <= qv[63];
					end
					dd_q <= 64'(fill_new_q); dr_q <= '0; dq_q <= '0;
					dcnt_q <= 7'd64; dop_q <= DIV_SSQ; state_q <= ST_DIV;
				end
				ST_VAR: begin
					logic signed [63:0] v;
					v = (dneg_q ? -$signed(dq_q) : $signed(dq_q)) - $signed(mul_p >> FRAC_BITS);
					if (v < 0) v = 0;
					if (v > $signed(VAR_CAP)) v = $signed(VAR_CAP);
					var_q <= 64'(v);
					x_q   <= (64'(v) < ONE_FP) ? ONE_FP : 64'(v);
					step_q <= '0;
					state_q <= (v == 0) ? ST_IDLE : ST_ROOTS;
				end
				ST_ROOTS: begin
					if (step_q == 5'd24) begin
						dev_q <= x_q; state_q <= ST_ZS;
					end else begin
						dn_q <= var_q << FRAC_BITS; dd_q <= x_q; dr_q <= '0; dq_q <= '0;
						dcnt_q <= 7'd64; dop_q <= DIV_ROOT; state_q <= ST_DIV;
					end
				end
				ST_ROOTN: begin
					if (newton_diff <= 1) begin
						dev_q <= 64'(newton_next); state_q <= ST_ZS;
					end else begin
						x_q <= 64'(newton_next); step_q <= step_q + 1'b1;
						state_q <= ST_ROOTS;
					end
				end
				ST_ZS: begin
					logic [63:0] d;
					logic signed [63:0] df;
					d = (dev_q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : dev_q;
					dev_q <= d;
					df = 64'(smp_q) - mean_q;
					if (d == 0) state_q <= ST_IDLE;
					else begin
						dn_q <= mag(df) << FRAC_BITS; dneg_q <= df[63]; dd_q <= d;
						dr_q <= '0; dq_q <= '0; dcnt_q <= 7'd64; dop_q <= DIV_Z;
						state_q <= ST_DIV;
					end
				end
				ST_ZDONE: begin
					logic signed [63:0] z, az;
					z = dneg_q ? -$signed(dq_q) : $signed(dq_q);
					if (dq_q[63] && !dneg_q) z = 64'sd2147483647;
					if (z > 64'sd2147483647) z = 64'sd2147483647;
					if (z < -64'sd2147483648) z = -64'sd2147483648;
					az = z[63] ? -z : z;
					z_q <= z;
					sev_q <= az >= 64'($signed({1'b0, thr_q, 1'b0}));
					state_q <= (az >= 64'(thr_q)) ? ST_OUT : ST_IDLE;
				end
				ST_OUT: if (!out_v_q) begin
					out_q <= {1'b0, z_q[31:0], dev_q[30:0], mean_q[31:0], smp_q,
						tag_q, ts_q};
					sev_out_q <= sev_q;
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_axis_tready |=> out_v_q && $stable(out_q))
		else $error("result lost while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_axis_tready)
		else $error("ready while busy");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && dcnt_q != 0 |=> state_q == ST_DIV)
		else $error("divider left early");

endmodule
